/* design/rpbm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpbm_pkg
// Shared types and constants of the region policy bank mapper.
// ----------------------------------------------------------------------------
package rpbm_pkg;

	localparam int LINE_W = 57;

	typedef enum logic [1:0] {
		POL_ROW_LOCAL = 2'd0,
		POL_BALANCED  = 2'd1,
		POL_HYBRID    = 2'd2,
		POL_MODULO    = 2'd3
	} policy_t;

	localparam logic [2:0] MODE_TABLE = 3'd4;

	typedef enum logic [1:0] {
		REG_REMAP_ENABLE = 2'd0,
		REG_MAP_MODE     = 2'd1,
		REG_BANK_COUNT   = 2'd2
	} reg_index_t;

	typedef enum logic {
		BK_IDLE = 1'b0,
		BK_DIV  = 1'b1
	} back_state_t;

	typedef struct packed {
		logic       remap_enable;
		logic [2:0] map_mode;
		logic [8:0] bank_count;
	} cfg_t;

	// classified map request handed from front to back
	typedef struct packed {
		logic [LINE_W-1:0] hash_x;
		logic [1:0]        tier;
		policy_t           policy;
		logic [7:0]        base_bank;
		logic [19:0]       base_row;
		logic [11:0]       base_col;
	} map_req_t;

endpackage

/* design/rpbm_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpbm_front
// Accepts requests, updates the region table and classifies map requests.
// ----------------------------------------------------------------------------
module rpbm_front #(
	parameter int REGION_ENTRIES = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  rpbm_pkg::cfg_t    cfg,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              req_type,
	input  logic [63:0]       addr,
	input  logic [7:0]        base_bank,
	input  logic [19:0]       base_row,
	input  logic [11:0]       base_col,
	input  logic [2:0]        entry_index,
	input  logic [63:0]       region_start,
	input  logic [63:0]       region_end,
	input  logic [1:0]        region_policy,
	input  logic              q_full,
	output logic              q_push,
	output rpbm_pkg::map_req_t q_data
);

	// entry_index reaches only eight slots
	localparam int SLOTS = (REGION_ENTRIES < 8) ? REGION_ENTRIES : 8;
	localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	logic [SLOTS-1:0] entry_valid_q;
	logic [63:0]      entry_start_q  [SLOTS];
	logic [63:0]      entry_end_q    [SLOTS];
	logic [1:0]       entry_policy_q [SLOTS];

	logic                       accept;
	logic                       wr_ok;
	logic [IDX_W-1:0]           wr_idx;
	logic [SLOTS-1:0]           hit;
	logic [1:0]                 table_pol;
	rpbm_pkg::policy_t          pol;
	logic [rpbm_pkg::LINE_W-1:0] ln;

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;
	assign wr_ok    = (int'(entry_index) < REGION_ENTRIES);
	assign wr_idx   = entry_index[IDX_W-1:0];

	// write valid bit of a region slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_valid_q <= '0;
		end else if (accept && req_type && wr_ok) begin
			entry_valid_q[wr_idx] <= (region_start <= region_end);
		end
	end

	// write region bounds and policy
	always_ff @(posedge clk) begin
		if (accept && req_type && wr_ok) begin
			entry_start_q[wr_idx]  <= region_start;
			entry_end_q[wr_idx]    <= region_end;
			entry_policy_q[wr_idx] <= region_policy;
		end
	end

	// match all slots, lowest slot wins
	always_comb begin
		for (int k = 0; k < SLOTS; k++) begin
			hit[k] = entry_valid_q[k] && (addr >= entry_start_q[k]) && (addr <= entry_end_q[k]);
		end
		table_pol = rpbm_pkg::POL_ROW_LOCAL;
		for (int k = SLOTS - 1; k >= 0; k--) begin
			if (hit[k]) begin
				table_pol = entry_policy_q[k];
			end
		end
	end

	// resolve policy
	always_comb begin
		priority if (cfg.map_mode < rpbm_pkg::MODE_TABLE) begin
			pol = rpbm_pkg::policy_t'(cfg.map_mode[1:0]);
		end else if (cfg.map_mode == rpbm_pkg::MODE_TABLE) begin
			pol = rpbm_pkg::policy_t'(table_pol);
		end else begin
			pol = rpbm_pkg::POL_MODULO;
		end
	end

	assign ln = addr[63:7];

	// hash word and tier tag
	always_comb begin
		q_data.policy    = pol;
		q_data.base_bank = base_bank;
		q_data.base_row  = base_row;
		q_data.base_col  = base_col;
		unique case (pol)
			rpbm_pkg::POL_ROW_LOCAL: begin
				q_data.hash_x = ln >> 6;
				q_data.tier   = ln[7:6];
			end
			rpbm_pkg::POL_BALANCED: begin
				q_data.hash_x = ln ^ (ln >> 7) ^ (ln >> 13);
				q_data.tier   = ln[1:0] ^ ln[6:5];
			end
			rpbm_pkg::POL_HYBRID: begin
				q_data.hash_x = (ln >> 6) ^ ln ^ (ln >> 9);
				q_data.tier   = ln[7:6] ^ ln[4:3];
			end
			default: begin
				q_data.hash_x = ln;
				q_data.tier   = 2'd0;
			end
		endcase
	end

	assign q_push = accept && !req_type;

endmodule

/* design/rpbm_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpbm_queue
// Two-entry queue between front and back.
// ----------------------------------------------------------------------------
module rpbm_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  rpbm_pkg::map_req_t push_data,
	output logic               full,
	input  logic               pop,
	output logic               not_empty,
	output rpbm_pkg::map_req_t pop_data
);

	rpbm_pkg::map_req_t mem_q [2];
	logic               wr_ptr_q;
	logic               rd_ptr_q;
	logic [1:0]         count_q;

	assign full      = (count_q == 2'd2);
	assign not_empty = (count_q != 2'd0);
	assign pop_data  = mem_q[rd_ptr_q];

	// store pushed request
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

/* design/rpbm_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpbm_back
// Reduces the hash word modulo the bank count one bit a cycle, or skips
// it with remap off or a zero count, and drives the result register.
// ----------------------------------------------------------------------------
module rpbm_back (
	input  logic               clk,
	input  logic               arst_n,
	input  rpbm_pkg::cfg_t     cfg,
	input  logic               q_not_empty,
	input  rpbm_pkg::map_req_t q_data,
	output logic               q_pop,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [7:0]         bank,
	output logic [19:0]        row,
	output logic [11:0]        col,
	output logic [1:0]         tier,
	output logic [1:0]         policy_used
);

	localparam int LW = rpbm_pkg::LINE_W;

	rpbm_pkg::back_state_t state_q, state_d;
	logic [LW-1:0] x_q;
	logic [8:0]    rem_q;
	logic [5:0]    cnt_q;
	logic          out_valid_q;
	logic          out_free;
	logic          start_div;
	logic          load_direct;
	logic          div_done;
	logic [9:0]    trial;
	logic [8:0]    rem_next;

	assign out_free = !out_valid_q || !out_stall;
	assign trial    = {rem_q, x_q[LW-1]};
	assign rem_next = (trial >= {1'b0, cfg.bank_count}) ?
		9'(trial - {1'b0, cfg.bank_count}) : trial[8:0];

	// next state and handshake
	always_comb begin
		state_d     = state_q;
		q_pop       = 1'b0;
		start_div   = 1'b0;
		load_direct = 1'b0;
		div_done    = 1'b0;
		unique case (state_q)
			rpbm_pkg::BK_IDLE: begin
				if (q_not_empty && out_free) begin
					q_pop = 1'b1;
					if (cfg.remap_enable && (cfg.bank_count != 9'd0)) begin
						start_div = 1'b1;
						state_d   = rpbm_pkg::BK_DIV;
					end else begin
						load_direct = 1'b1;
					end
				end
			end
			rpbm_pkg::BK_DIV: begin
				if (cnt_q == 6'd0) begin
					div_done = 1'b1;
					state_d  = rpbm_pkg::BK_IDLE;
				end
			end
			default: state_d = rpbm_pkg::BK_IDLE;
		endcase
	end

	// hold state and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rpbm_pkg::BK_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_direct || div_done) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// iterate the remainder, msb first
	always_ff @(posedge clk) begin
		if (start_div) begin
			x_q   <= q_data.hash_x;
			rem_q <= 9'd0;
			cnt_q <= 6'(LW - 1);
		end else if (state_q == rpbm_pkg::BK_DIV) begin
			x_q   <= x_q << 1;
			rem_q <= rem_next;
			cnt_q <= cnt_q - 6'd1;
		end
	end

	// load result payload
	always_ff @(posedge clk) begin
		if (q_pop) begin
			row         <= q_data.base_row;
			col         <= q_data.base_col;
			policy_used <= q_data.policy;
			tier        <= cfg.remap_enable ? q_data.tier : 2'd0;
			bank        <= cfg.remap_enable ? 8'd0 : q_data.base_bank;
		end else if (div_done) begin
			bank <= rem_next[7:0];
		end
	end

	assign out_valid = out_valid_q;

endmodule

/* design/region_policy_bank_mapper.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// region_policy_bank_mapper
// Memory-controller address remapper with a region policy table.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall) carries map requests (req_type 0) and
// region table writes (req_type 1). A write updates the table and gives no
// result; a map request gives one result on out_valid/out_stall.
// The front accepts a request whenever its two-entry queue has room and
// resolves the policy against all table slots at once.
// The back takes one request at a time. With remapping off or a bank count
// of zero the result is registered in the cycle after the pop; otherwise the
// bank is the remainder of a 57-bit hash word by bank_count, built one bit a
// cycle, and the back takes no new map request until that remainder is done.
// Results wait in the output register while out_stall is high; the back then
// holds the next request and the front fills the queue before raising
// in_stall. Reset clears the table valid bits, the queue and the result
// valid bit, and sets remap off, mode row local and 16 banks. The user writes
// configuration via cfg_we/cfg_index/cfg_wdata only while idle; not enforced.
// ----------------------------------------------------------------------------
module region_policy_bank_mapper #(
	parameter int REGION_ENTRIES = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [8:0]  cfg_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        req_type,
	input  logic [63:0] addr,
	input  logic [7:0]  base_bank,
	input  logic [19:0] base_row,
	input  logic [11:0] base_col,
	input  logic [2:0]  entry_index,
	input  logic [63:0] region_start,
	input  logic [63:0] region_end,
	input  logic [1:0]  region_policy,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  bank,
	output logic [19:0] row,
	output logic [11:0] col,
	output logic [1:0]  tier,
	output logic [1:0]  policy_used
);

	rpbm_pkg::cfg_t     cfg_q;
	rpbm_pkg::map_req_t push_data;
	rpbm_pkg::map_req_t pop_data;
	logic               q_full;
	logic               q_push;
	logic               q_pop;
	logic               q_not_empty;

	// write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.remap_enable <= 1'b0;
			cfg_q.map_mode     <= 3'd0;
			cfg_q.bank_count   <= 9'd16;
		end else if (cfg_we) begin
			unique case (cfg_index)
				rpbm_pkg::REG_REMAP_ENABLE: cfg_q.remap_enable <= cfg_wdata[0];
				rpbm_pkg::REG_MAP_MODE:     cfg_q.map_mode     <= cfg_wdata[2:0];
				rpbm_pkg::REG_BANK_COUNT:   cfg_q.bank_count   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	rpbm_front #(
		.REGION_ENTRIES(REGION_ENTRIES)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.req_type     (req_type),
		.addr         (addr),
		.base_bank    (base_bank),
		.base_row     (base_row),
		.base_col     (base_col),
		.entry_index  (entry_index),
		.region_start (region_start),
		.region_end   (region_end),
		.region_policy(region_policy),
		.q_full       (q_full),
		.q_push       (q_push),
		.q_data       (push_data)
	);

	rpbm_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_data(push_data),
		.full     (q_full),
		.pop      (q_pop),
		.not_empty(q_not_empty),
		.pop_data (pop_data)
	);

	rpbm_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.q_not_empty(q_not_empty),
		.q_data     (pop_data),
		.q_pop      (q_pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.bank       (bank),
		.row        (row),
		.col        (col),
		.tier       (tier),
		.policy_used(policy_used)
	);

endmodule

/* design/rpbm_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpbm_checker
// Port-level checks of the region policy bank mapper.
// ----------------------------------------------------------------------------
module rpbm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic [7:0]  bank,
	input logic [19:0] row,
	input logic [11:0] col,
	input logic [1:0]  tier,
	input logic [1:0]  policy_used
);

	// hold a stalled result
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(bank) && $stable(row) &&
			$stable(col) && $stable(tier) && $stable(policy_used))
		else $error("stalled result changed");

	// modulo policy carries no tier
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (policy_used == rpbm_pkg::POL_MODULO) |-> tier == 2'd0)
		else $error("tier set under modulo policy");

	// no result right out of reset
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !out_valid)
		else $error("result valid after reset");

endmodule

bind region_policy_bank_mapper rpbm_checker u_rpbm_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.bank       (bank),
	.row        (row),
	.col        (col),
	.tier       (tier),
	.policy_used(policy_used)
);
